// File: hw/rtl/htfd_pkg.sv
`timescale 1ns / 1ps

package htfd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Position of a byte inside the six-byte measurement frame.
  localparam logic [2:0] IDX_TEMP_MSB = 3'd0;
  localparam logic [2:0] IDX_TEMP_LSB = 3'd1;
  localparam logic [2:0] IDX_TEMP_CRC = 3'd2;
  localparam logic [2:0] IDX_HUM_MSB  = 3'd3;
  localparam logic [2:0] IDX_HUM_LSB  = 3'd4;
  localparam logic [2:0] IDX_HUM_CRC  = 3'd5;

  localparam logic [12:0] TempGain   = 13'd4375;
  localparam logic [15:0] TempOffset = 16'd4500;
  localparam logic [9:0]  HumGain    = 10'd625;

  typedef struct packed {
    logic               valid;
    logic signed [14:0] temp_centi;
    logic        [13:0] hum_centi;
    logic               temp_crc_ok;
    logic               hum_crc_ok;
  } htfd_result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/htfd_frame_core.sv
`timescale 1ns / 1ps

module htfd_frame_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  output htfd_pkg::htfd_result_t res
);

  logic [2:0]  byte_index;
  logic [2:0]  byte_index_next;
  logic [7:0]  crc_accum;
  logic [7:0]  crc_accum_next;
  logic [15:0] temp_word;
  logic [15:0] temp_word_next;
  logic [15:0] hum_word;
  logic [15:0] hum_word_next;
  logic        temp_check_pass;
  logic        temp_check_pass_next;

  logic        restart;
  logic [2:0]  idx;
  logic [7:0]  crc_base;
  logic [7:0]  crc_new;
  logic [28:0] temp_prod;
  logic [25:0] hum_prod;
  logic [15:0] temp_diff;

  // A flagged byte, or a count that somehow left the frame, begins a new frame.
  assign restart  = frame_start || (byte_index > htfd_pkg::IDX_HUM_CRC);
  assign idx      = restart ? htfd_pkg::IDX_TEMP_MSB : byte_index;
  assign crc_base = restart ? htfd_pkg::CrcInit : crc_accum;
  assign crc_new  = htfd_pkg::crc8_byte(crc_base, rx_byte);

  assign temp_prod = 29'(temp_word) * 29'(htfd_pkg::TempGain);
  assign hum_prod  = 26'(hum_word) * 26'(htfd_pkg::HumGain);
  assign temp_diff = {1'b0, temp_prod[28:14]} - htfd_pkg::TempOffset;

  always_comb begin
    byte_index_next      = idx + 3'd1;
    crc_accum_next       = crc_new;
    temp_word_next       = temp_word;
    hum_word_next        = hum_word;
    temp_check_pass_next = temp_check_pass;
    res.valid            = 1'b0;
    res.temp_centi       = temp_diff[14:0];
    res.hum_centi        = hum_prod[25:12];
    res.temp_crc_ok      = temp_check_pass;
    res.hum_crc_ok       = (rx_byte == crc_base);
    unique case (idx)
      htfd_pkg::IDX_TEMP_MSB: temp_word_next = {rx_byte, temp_word[7:0]};
      htfd_pkg::IDX_TEMP_LSB: temp_word_next = {temp_word[15:8], rx_byte};
      htfd_pkg::IDX_TEMP_CRC: begin
        temp_check_pass_next = (rx_byte == crc_base);
        crc_accum_next       = htfd_pkg::CrcInit;
      end
      htfd_pkg::IDX_HUM_MSB: hum_word_next = {rx_byte, hum_word[7:0]};
      htfd_pkg::IDX_HUM_LSB: hum_word_next = {hum_word[15:8], rx_byte};
      htfd_pkg::IDX_HUM_CRC: begin
        res.valid       = en;
        crc_accum_next  = htfd_pkg::CrcInit;
        byte_index_next = htfd_pkg::IDX_TEMP_MSB;
      end
      default: begin
        crc_accum_next  = htfd_pkg::CrcInit;
        byte_index_next = htfd_pkg::IDX_TEMP_MSB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index      <= htfd_pkg::IDX_TEMP_MSB;
      crc_accum       <= htfd_pkg::CrcInit;
      temp_word       <= '0;
      hum_word        <= '0;
      temp_check_pass <= 1'b0;
    end else if (en) begin
      byte_index      <= byte_index_next;
      crc_accum       <= crc_accum_next;
      temp_word       <= temp_word_next;
      hum_word        <= hum_word_next;
      temp_check_pass <= temp_check_pass_next;
    end
  end

endmodule

// File: hw/rtl/humidity_temp_frame_decoder.sv
`timescale 1ns / 1ps

// Channel   Dir  tdata                                   tuser
// s_*       in   [7:0] rx_byte                           [0] frame_start
// m_*       out  [14:0] temp_centi, [28:15] hum_centi    [0] temp_crc_ok, [1] hum_crc_ok
//
// One byte request per cycle is taken while the output side keeps up.
// A byte is held in the input register; the frame logic (CRC and the
// two constant multiplies) runs from there into the result register.
// A held result stalls the input register, which then drops s_tready.
// rst clears the frame count, the CRC, and both valid flags.

module humidity_temp_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [14:0] temp_centi, [28:15] hum_centi, [31:29] zero
  output logic [1:0]  m_tuser    // [0] temp_crc_ok, [1] hum_crc_ok
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_start;
  logic                   adv;
  htfd_pkg::htfd_result_t core_res;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  htfd_frame_core u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .rx_byte     (in_byte),
    .frame_start (in_start),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (core_res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res.valid) begin
      m_tdata <= {3'b000, core_res.hum_centi, core_res.temp_centi};
      m_tuser <= {core_res.hum_crc_ok, core_res.temp_crc_ok};
    end
  end

`ifndef ASSERT_OFF
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_result_only_when_advancing: assert property (@(posedge clk) disable iff (rst)
    core_res.valid |-> adv && !in_start)
    else $error("result produced without a byte moving through");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    core_res.valid |=> m_tvalid)
    else $error("produced result did not reach the output register");

  a_held_input_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |-> !s_tready && !core_res.valid)
    else $error("input taken or result made while output is stalled");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int WatchdogLimit = 2000;
  localparam int ItemsPerPhase = 550;
  localparam int TailCycles    = 12;
  localparam int TempShift     = 14;
  localparam int HumShift      = 12;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic        [13:0] hum_centi;
    logic               temp_crc_ok;
    logic               hum_crc_ok;
  } reading_t;

  // One byte request, with an optional hand-written reading for the sixth byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       typed;
    reading_t   want;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic        s_tuser = 1'b0; // [0] frame_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [14:0] temp_centi, [28:15] hum_centi, [31:29] zero
  logic [1:0]  m_tuser;        // [0] temp_crc_ok, [1] hum_crc_ok

  humidity_temp_frame_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int bytes_sent = 0;
  int readings_seen = 0;
  int crc_fail_seen = 0;
  int stall_cycles = 0;

  reading_t pending_readings[$];
  reading_t oldest;
  byte_req_t directed_reqs [26];

  // Frame tracking state of the decoder.
  logic [2:0]  frame_pos = htfd_pkg::IDX_TEMP_MSB;
  logic [7:0]  crc_run = htfd_pkg::CrcInit;
  logic [15:0] temp_raw = '0;
  logic [15:0] hum_raw = '0;
  logic        temp_ok_held = 1'b0;

  // Bitwise MSB-first form of the CRC: feedback is the top CRC bit xor the data bit.
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] c;
    logic fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CrcPoly : 8'h00);
    end
    return c;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic st, output logic produced,
                             output reading_t r);
    logic [2:0] pos;
    int t;
    int h;
    produced = 1'b0;
    r = '0;
    pos = frame_pos;
    if (st || pos > htfd_pkg::IDX_HUM_CRC) begin
      pos = htfd_pkg::IDX_TEMP_MSB;
      crc_run = htfd_pkg::CrcInit;
    end
    case (pos)
      htfd_pkg::IDX_TEMP_MSB: begin
        crc_run = crc8_step(crc_run, b);
        temp_raw[15:8] = b;
      end
      htfd_pkg::IDX_TEMP_LSB: begin
        crc_run = crc8_step(crc_run, b);
        temp_raw[7:0] = b;
      end
      htfd_pkg::IDX_TEMP_CRC: begin
        temp_ok_held = (b == crc_run);
        crc_run = htfd_pkg::CrcInit;
      end
      htfd_pkg::IDX_HUM_MSB: begin
        crc_run = crc8_step(crc_run, b);
        hum_raw[15:8] = b;
      end
      htfd_pkg::IDX_HUM_LSB: begin
        crc_run = crc8_step(crc_run, b);
        hum_raw[7:0] = b;
      end
      default: begin
        t = int'((32'(htfd_pkg::TempGain) * 32'(temp_raw)) >> TempShift)
            - int'(htfd_pkg::TempOffset);
        h = int'((32'(htfd_pkg::HumGain) * 32'(hum_raw)) >> HumShift);
        r.temp_centi = t[14:0];
        r.hum_centi = h[13:0];
        r.temp_crc_ok = temp_ok_held;
        r.hum_crc_ok = (b == crc_run);
        crc_run = htfd_pkg::CrcInit;
        produced = 1'b1;
      end
    endcase
    frame_pos = produced ? htfd_pkg::IDX_TEMP_MSB : pos + 3'd1;
  endtask

  function automatic byte_req_t plain_req(input logic [7:0] b, input logic st);
    byte_req_t q;
    q = '0;
    q.rx_byte = b;
    q.frame_start = st;
    return q;
  endfunction

  function automatic byte_req_t known_req(input logic [7:0] b, input logic st, input int t,
                                          input int h, input logic tok, input logic hok);
    byte_req_t q;
    q = plain_req(b, st);
    q.typed = 1'b1;
    q.want.temp_centi = t[14:0];
    q.want.hum_centi = h[13:0];
    q.want.temp_crc_ok = tok;
    q.want.hum_crc_ok = hok;
    return q;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d (reading %0d)", what, got, want, readings_seen);
    mismatch_count++;
  endtask

  // Entered and left at a falling edge.
  task automatic drive_byte(input byte_req_t req);
    logic produced;
    reading_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= req.rx_byte;
    s_tuser <= req.frame_start;
    do @(posedge clk); while (!s_tready);
    decode_byte(req.rx_byte, req.frame_start, produced, pred);
    if (produced) pending_readings.push_back(req.typed ? req.want : pred);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_burst(inout int count);
    int kind;
    int len;
    logic [15:0] tw;
    logic [15:0] hw;
    logic [7:0] frame_bytes [6];
    logic st0;
    kind = $urandom_range(99);
    if (kind < 75) begin
      // Well-formed frame with random words, occasionally a corrupted check byte.
      tw = pick_word();
      hw = pick_word();
      frame_bytes[0] = tw[15:8];
      frame_bytes[1] = tw[7:0];
      frame_bytes[2] = crc8_step(crc8_step(htfd_pkg::CrcInit, tw[15:8]), tw[7:0]);
      frame_bytes[3] = hw[15:8];
      frame_bytes[4] = hw[7:0];
      frame_bytes[5] = crc8_step(crc8_step(htfd_pkg::CrcInit, hw[15:8]), hw[7:0]);
      if ($urandom_range(99) < 15) frame_bytes[2] ^= 8'($urandom_range(255, 1));
      if ($urandom_range(99) < 15) frame_bytes[5] ^= 8'($urandom_range(255, 1));
      st0 = ($urandom_range(99) < 70);
      for (int i = 0; i < 6; i++) drive_byte(plain_req(frame_bytes[i], (i == 0) ? st0 : 1'b0));
      count += 6;
    end else if (kind < 88) begin
      // Truncated frame; whatever follows either restarts or continues it.
      len = $urandom_range(5, 1);
      for (int i = 0; i < len; i++) drive_byte(plain_req(8'($urandom), i == 0));
      count += len;
    end else begin
      len = $urandom_range(4, 1);
      for (int i = 0; i < len; i++) drive_byte(plain_req(8'($urandom), 1'($urandom)));
      count += len;
    end
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      readings_seen++;
      if (!m_tuser[0] || !m_tuser[1]) crc_fail_seen++;
      if (pending_readings.size() == 0) begin
        report_mismatch("reading with none pending", int'(m_tdata), 0);
      end else begin
        oldest = pending_readings.pop_front();
        if ($signed(m_tdata[14:0]) != oldest.temp_centi)
          report_mismatch("temp_centi", int'($signed(m_tdata[14:0])), int'(oldest.temp_centi));
        if (m_tdata[28:15] != oldest.hum_centi)
          report_mismatch("hum_centi", int'(m_tdata[28:15]), int'(oldest.hum_centi));
        if (m_tdata[31:29] != 3'b000)
          report_mismatch("tdata padding", int'(m_tdata[31:29]), 0);
        if (m_tuser[0] != oldest.temp_crc_ok)
          report_mismatch("temp_crc_ok", int'(m_tuser[0]), int'(oldest.temp_crc_ok));
        if (m_tuser[1] != oldest.hum_crc_ok)
          report_mismatch("hum_crc_ok", int'(m_tuser[1]), int'(oldest.hum_crc_ok));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("Timeout: no request moved for %0d cycles", stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int phase_count;
    directed_reqs = '{
      // All-zero words with matching check bytes.
      plain_req(8'h00, 1'b1), plain_req(8'h00, 1'b0), plain_req(8'h81, 1'b0),
      plain_req(8'h00, 1'b0), plain_req(8'h00, 1'b0),
      known_req(8'h81, 1'b0, -4500, 0, 1'b1, 1'b1),
      // All-ones words with matching check bytes.
      plain_req(8'hFF, 1'b1), plain_req(8'hFF, 1'b0), plain_req(8'hAC, 1'b0),
      plain_req(8'hFF, 1'b0), plain_req(8'hFF, 1'b0),
      known_req(8'hAC, 1'b0, 12999, 9999, 1'b1, 1'b1),
      // No start flag: the count wrapped, and both check bytes are wrong.
      plain_req(8'h00, 1'b0), plain_req(8'h00, 1'b0), plain_req(8'h00, 1'b0),
      plain_req(8'h00, 1'b0), plain_req(8'h00, 1'b0),
      known_req(8'h00, 1'b0, -4500, 0, 1'b0, 1'b0),
      // A new start flag abandons the partial frame.
      plain_req(8'h12, 1'b1), plain_req(8'h34, 1'b0),
      plain_req(8'hBE, 1'b1), plain_req(8'hEF, 1'b0), plain_req(8'h92, 1'b0),
      plain_req(8'h00, 1'b0), plain_req(8'h00, 1'b0), plain_req(8'h81, 1'b0)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed_reqs[i]) drive_byte(directed_reqs[i]);
      end
      phase_count = 0;
      while (phase_count < ItemsPerPhase) send_random_burst(phase_count);
    end
    s_tvalid <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d frame bytes under three handshake pacing mixes.", bytes_sent);
    $display("Checked %0d readings, %0d of them with a failed check byte; %0d mismatches.",
             readings_seen, crc_fail_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
